FILE: rtl/tola_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tola_pkg
// Shared types and constants of the ticket order lock arbiter.
// ----------------------------------------------------------------------------
package tola_pkg;

  localparam int MAX_REQ_DEF     = 8;
  localparam int TICKET_BITS_DEF = 16;

  localparam int ID_W     = 3;
  localparam int CNT_W    = 4;
  localparam int ISSUED_W = 16;
  localparam int ERR_W    = 2;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic {
    REQ_LOCK   = 1'b0,
    REQ_UNLOCK = 1'b1
  } req_type_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_RANGE    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } owner_t;

endpackage

FILE: rtl/tola_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tola_scan
// Reduction trees over the ticket table: largest active ticket, and the
// owner (smallest nonzero ticket, lowest id on ties) over all active entries
// and over the active entries other than one excluded id.
// ----------------------------------------------------------------------------
module tola_scan #(
  parameter int MAX_REQUESTERS = tola_pkg::MAX_REQ_DEF,
  parameter int TICKET_BITS    = tola_pkg::TICKET_BITS_DEF
) (
  input  logic [TICKET_BITS-1:0]   tickets_i [MAX_REQUESTERS],
  input  logic [tola_pkg::CNT_W-1:0] count_i,
  input  logic                     excl_en_i,
  input  logic [tola_pkg::ID_W-1:0]  excl_id_i,
  output logic [TICKET_BITS-1:0]   top_o,
  output tola_pkg::owner_t         own_all_o,
  output tola_pkg::owner_t         own_excl_o
);
  import tola_pkg::*;

  localparam int LVL   = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int N2    = 1 << LVL;
  localparam int NODES = 2 * N2 - 1;
  localparam int IDX_W = LVL;

  logic [TICKET_BITS-1:0] mx    [NODES];
  logic [TICKET_BITS-1:0] a_val [NODES];
  logic [IDX_W-1:0]       a_idx [NODES];
  logic                   a_ok  [NODES];
  logic [TICKET_BITS-1:0] e_val [NODES];
  logic [IDX_W-1:0]       e_idx [NODES];
  logic                   e_ok  [NODES];

  always_comb begin
    logic act;
    logic nz;
    logic ex;
    int   l;
    int   r;
    for (int k = 0; k < N2; k++) begin
      if (k < MAX_REQUESTERS) begin
        act = (k < 32'(count_i));
        nz  = (tickets_i[k] != '0);
        ex  = excl_en_i && (32'(excl_id_i) == k);
        mx[N2-1+k]    = act ? tickets_i[k] : '0;
        a_val[N2-1+k] = tickets_i[k];
        a_idx[N2-1+k] = IDX_W'(k);
        a_ok[N2-1+k]  = act && nz;
        e_val[N2-1+k] = tickets_i[k];
        e_idx[N2-1+k] = IDX_W'(k);
        e_ok[N2-1+k]  = act && nz && !ex;
      end else begin
        mx[N2-1+k]    = '0;
        a_val[N2-1+k] = '0;
        a_idx[N2-1+k] = '0;
        a_ok[N2-1+k]  = 1'b0;
        e_val[N2-1+k] = '0;
        e_idx[N2-1+k] = '0;
        e_ok[N2-1+k]  = 1'b0;
      end
    end
    // left subtree holds lower ids, so it wins ties
    for (int k = N2 - 2; k >= 0; k--) begin
      l = 2 * k + 1;
      r = 2 * k + 2;
      mx[k] = (mx[l] >= mx[r]) ? mx[l] : mx[r];
      if (a_ok[l] && (!a_ok[r] || a_val[l] <= a_val[r])) begin
        a_val[k] = a_val[l];
        a_idx[k] = a_idx[l];
      end else begin
        a_val[k] = a_val[r];
        a_idx[k] = a_idx[r];
      end
      a_ok[k] = a_ok[l] || a_ok[r];
      if (e_ok[l] && (!e_ok[r] || e_val[l] <= e_val[r])) begin
        e_val[k] = e_val[l];
        e_idx[k] = e_idx[l];
      end else begin
        e_val[k] = e_val[r];
        e_idx[k] = e_idx[r];
      end
      e_ok[k] = e_ok[l] || e_ok[r];
    end
  end

  assign top_o            = mx[0];
  assign own_all_o.valid  = a_ok[0];
  assign own_all_o.id     = a_ok[0] ? ID_W'(a_idx[0]) : '0;
  assign own_excl_o.valid = e_ok[0];
  assign own_excl_o.id    = e_ok[0] ? ID_W'(e_idx[0]) : '0;

endmodule

FILE: rtl/ticket_order_lock_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_order_lock_arbiter
// Lock arbiter that grants in ticket order: lock requests draw a ticket one
// above the largest held, unlocks drop it, and every transaction reports
// the current owner.
// Accepted transactions wait in the input register; results go to the
// result register. Throughput: one transaction per cycle unless the output
// stalls; the table update and both reduction trees settle between them.
// Reset: all tickets cleared, active_count set to 8, both stages empty.
// ----------------------------------------------------------------------------
module ticket_order_lock_arbiter #(
  parameter int MAX_REQUESTERS = tola_pkg::MAX_REQ_DEF,
  parameter int TICKET_BITS    = tola_pkg::TICKET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tola_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [tola_pkg::ID_W-1:0]     requester_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          owner_valid_o,
  output logic [tola_pkg::ID_W-1:0]     owner_id_o,
  output logic [tola_pkg::ISSUED_W-1:0] ticket_issued_o,
  output logic [tola_pkg::ERR_W-1:0]    error_code_o
);
  import tola_pkg::*;

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

  logic [CNT_W-1:0]       active_count_q;
  logic [TICKET_BITS-1:0] tickets_q [MAX_REQUESTERS];

  logic                   in_valid_q;
  req_type_e              req_q;
  logic [ID_W-1:0]        id_q;

  logic                   out_valid_q;
  owner_t                 owner_q, owner_d;
  logic [ISSUED_W-1:0]    issued_q, issued_d;
  err_e                   err_q, err_d;

  logic                   res_free;
  logic                   adv;
  logic                   accept;
  logic                   in_range;
  logic                   is_lock;
  logic                   overflow;
  logic                   change;
  logic [TICKET_BITS-1:0] top;
  logic [TICKET_BITS-1:0] new_ticket;
  owner_t                 own_all;
  owner_t                 own_excl;

  assign res_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && res_free;
  assign in_stall_o = in_valid_q && !res_free;
  assign accept     = in_valid_i && !in_stall_o;

  tola_scan #(
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .TICKET_BITS    (TICKET_BITS)
  ) u_scan (
    .tickets_i  (tickets_q),
    .count_i    (active_count_q),
    .excl_en_i  (change),
    .excl_id_i  (id_q),
    .top_o      (top),
    .own_all_o  (own_all),
    .own_excl_o (own_excl)
  );

  assign in_range   = (32'(id_q) < MAX_REQUESTERS) && ({1'b0, id_q} < active_count_q);
  assign is_lock    = (req_q == REQ_LOCK);
  assign overflow   = (top == TICKET_MAX);
  assign change     = in_range && !(is_lock && overflow);
  assign new_ticket = is_lock ? (top + TICKET_BITS'(1)) : '0;

  always_comb begin
    err_d    = ERR_OK;
    issued_d = '0;
    owner_d  = own_all;
    if (!in_range) begin
      err_d = ERR_RANGE;
    end else if (is_lock && overflow) begin
      err_d = ERR_OVERFLOW;
    end else if (is_lock) begin
      issued_d = ISSUED_W'(new_ticket);
      // new ticket is above every active one
      owner_d  = own_excl.valid ? own_excl : owner_t'{valid: 1'b1, id: id_q};
    end else begin
      owner_d  = own_excl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ACTIVE_RESET;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < MAX_REQUESTERS; i++) begin
        tickets_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_count_q <= cfg_wdata_i;
      end
      in_valid_q  <= accept || (in_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && out_stall_i);
      for (int i = 0; i < MAX_REQUESTERS; i++) begin
        if (adv && change && (32'(id_q) == i)) begin
          tickets_q[i] <= new_ticket;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_e'(req_type_i);
      id_q  <= requester_id_i;
    end
    if (adv) begin
      owner_q  <= owner_d;
      issued_q <= issued_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign owner_valid_o   = owner_q.valid;
  assign owner_id_o      = owner_q.id;
  assign ticket_issued_o = issued_q;
  assign error_code_o    = err_q;

  a_issue_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && issued_q != '0) |-> (err_q == ERR_OK && owner_q.valid))
    else $error("ticket issued with error or without owner");

  a_owner_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && owner_q.valid) |-> ({1'b0, owner_q.id} < active_count_q))
    else $error("owner outside active requesters");

  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(id_q) && $stable(req_q)))
    else $error("input register lost a waiting transaction");

endmodule

FILE: tb/ticket_order_lock_arbiter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticket_order_lock_arbiter_test
// Drives lock and unlock transactions into the ticket order lock arbiter and
// checks every reported owner, issued ticket and error code against a
// scoreboard that keeps its own ticket table. Covers a directed sequence
// and random phases under several active counts and idle/stall mixes,
// including one long output hold-off.
// ----------------------------------------------------------------------------
module ticket_order_lock_arbiter_test;
  import tola_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 195;

  typedef struct packed {
    logic                held;
    logic [ID_W-1:0]     owner;
    logic [ISSUED_W-1:0] ticket;
    err_e                err;
  } grant_t;

  class lock_scoreboard;
    bit [ISSUED_W-1:0] tickets [MAX_REQ_DEF];
    bit [CNT_W-1:0]    count_reg;
    grant_t            grant_q [$];
    int                mismatches;

    function int active_n();
      return (count_reg > MAX_REQ_DEF) ? MAX_REQ_DEF : int'(count_reg);
    endfunction

    function bit [ISSUED_W-1:0] top_ticket();
      bit [ISSUED_W-1:0] top;
      top = '0;
      for (int i = 0; i < active_n(); i++)
        if (tickets[i] > top) top = tickets[i];
      return top;
    endfunction

    function void note_request(req_type_e kind, logic [ID_W-1:0] id);
      grant_t            g;
      bit [ISSUED_W-1:0] top;
      bit [ISSUED_W-1:0] lowest;
      int                n;
      n        = active_n();
      g.held   = 1'b0;
      g.owner  = '0;
      g.ticket = '0;
      g.err    = ERR_OK;
      lowest   = '0;
      if (int'(id) >= n) begin
        g.err = ERR_RANGE;
      end else if (kind == REQ_LOCK) begin
        top = top_ticket();
        if (top == '1) begin
          g.err = ERR_OVERFLOW;
        end else begin
          tickets[id] = top + 1'b1;
          g.ticket    = tickets[id];
        end
      end else begin
        tickets[id] = '0;
      end
      for (int i = 0; i < n; i++) begin
        if (tickets[i] != 0 && (!g.held || tickets[i] < lowest)) begin
          g.held  = 1'b1;
          lowest  = tickets[i];
          g.owner = i[ID_W-1:0];
        end
      end
      grant_q.push_back(g);
    endfunction

    function void check_result(logic held, logic [ID_W-1:0] owner,
                               logic [ISSUED_W-1:0] ticket, logic [ERR_W-1:0] err);
      grant_t want;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result held=%0d owner=%0d ticket=%0d err=%0d",
                   $realtime, held, owner, ticket, err);
        return;
      end
      want = grant_q.pop_front();
      if (held !== want.held || owner !== want.owner ||
          ticket !== want.ticket || err !== want.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $realtime, want.held, want.owner, want.ticket, want.err,
                   held, owner, ticket, err);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = 1'b0;
  logic [ID_W-1:0]     requester_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                owner_valid_o;
  logic [ID_W-1:0]     owner_id_o;
  logic [ISSUED_W-1:0] ticket_issued_o;
  logic [ERR_W-1:0]    error_code_o;

  lock_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  ticket_order_lock_arbiter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .requester_id_i  (requester_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .owner_valid_o   (owner_valid_o),
    .owner_id_o      (owner_id_o),
    .ticket_issued_o (ticket_issued_o),
    .error_code_o    (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(owner_valid_o, owner_id_o, ticket_issued_o, error_code_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic set_mode(int m);
    send_idle_pct  = (m == 1) ? 59 : (m == 3) ? 7 : 0;
    recv_stall_pct = (m == 2) ? 59 : (m == 3) ? 7 : 0;
  endtask

  task automatic send_item(req_type_e kind, logic [ID_W-1:0] id);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    requester_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, id);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.grant_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_active(logic [CNT_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.count_reg = v;
  endtask

  task automatic random_item();
    int n;
    logic [ID_W-1:0] id;
    n = sb.active_n();
    if (n == 0 || $urandom_range(9) == 0) id = ID_W'($urandom_range(7));
    else id = ID_W'($urandom_range(n - 1));
    send_item(($urandom_range(99) < 55) ? REQ_LOCK : REQ_UNLOCK, id);
  endtask

  initial begin
    logic [CNT_W-1:0] counts [8];
    counts = '{4'd8, 4'd1, 4'd15, 4'd2, 4'd5, 4'd3, 4'd8, 4'd6};
    sb = new();
    sb.count_reg = ACTIVE_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unlock without ticket, relock, ownership handoff
    set_mode(0);
    send_item(REQ_UNLOCK, 3'd0);
    send_item(REQ_LOCK, 3'd0);
    send_item(REQ_LOCK, 3'd7);
    send_item(REQ_LOCK, 3'd3);
    send_item(REQ_LOCK, 3'd0);
    send_item(REQ_UNLOCK, 3'd7);
    send_item(REQ_UNLOCK, 3'd3);
    send_item(REQ_LOCK, 3'd5);
    send_item(REQ_UNLOCK, 3'd0);
    // inactive holder, out of range ids
    set_active(4'd3);
    send_item(REQ_LOCK, 3'd5);
    send_item(REQ_LOCK, 3'd1);
    send_item(REQ_UNLOCK, 3'd7);
    set_active(4'd0);
    send_item(REQ_LOCK, 3'd0);
    send_item(REQ_UNLOCK, 3'd2);
    // count above max, tie on equal tickets
    set_active(4'd15);
    send_item(REQ_UNLOCK, 3'd1);
    send_item(REQ_UNLOCK, 3'd5);
    send_item(REQ_LOCK, 3'd6);
    set_active(4'd1);
    send_item(REQ_LOCK, 3'd0);
    send_item(REQ_LOCK, 3'd1);
    set_active(4'd8);
    send_item(REQ_LOCK, 3'd4);
    send_item(REQ_UNLOCK, 3'd0);
    send_item(REQ_UNLOCK, 3'd6);

    for (int ph = 0; ph < 8; ph++) begin
      set_active((ph == 7) ? 4'($urandom_range(1, 15)) : counts[ph]);
      set_mode(ph % 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 20) hold_request = 1;
        random_item();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.grant_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
